>>> src/itrn_pkg.sv
package itrn_pkg;

  localparam int VALUE_W  = 16;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int REM_W    = 12;
  localparam int STEP_W   = 5;

  localparam logic [VALUE_W-1:0] MAX_VALUE = VALUE_W'(3999);
  localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(18);

  localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
  localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
  localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
  localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
  localparam logic [CHAR_W-1:0] CH_I    = 8'h49;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_RPT     = 2'd0,
    OP_PAIR_HI = 2'd1,
    OP_PAIR_LO = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] chr;
    logic [REM_W-1:0]  amount;
  } ucode_t;

  typedef struct packed {
    logic ge;
    logic drain;
  } dp_flags_t;

  typedef struct packed {
    logic emit;
    logic sub;
    logic last;
  } seq_ctl_t;

endpackage

>>> src/itrn_if.sv
interface itrn_in_if;
  logic                          valid;
  logic                          ready;
  logic [itrn_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itrn_out_if;
  logic                           valid;
  logic                           ready;
  logic [itrn_pkg::CHAR_W-1:0]    char_code;
  logic                           last;
  logic [itrn_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output char_code, output last, output status, input ready);
  modport sink   (input valid, input char_code, input last, input status, output ready);
endinterface

>>> src/itrn_rom.sv
module itrn_rom (
  input  logic [itrn_pkg::STEP_W-1:0] step,
  output itrn_pkg::ucode_t            word
);

  always_comb begin
    unique case (step)
      5'd0:    word = '{itrn_pkg::OP_RPT,     itrn_pkg::CH_M, 12'd1000};
      5'd1:    word = '{itrn_pkg::OP_PAIR_HI, itrn_pkg::CH_C, 12'd900};
      5'd2:    word = '{itrn_pkg::OP_PAIR_LO, itrn_pkg::CH_M, 12'd900};
      5'd3:    word = '{itrn_pkg::OP_RPT,     itrn_pkg::CH_D, 12'd500};
      5'd4:    word = '{itrn_pkg::OP_PAIR_HI, itrn_pkg::CH_C, 12'd400};
      5'd5:    word = '{itrn_pkg::OP_PAIR_LO, itrn_pkg::CH_D, 12'd400};
      5'd6:    word = '{itrn_pkg::OP_RPT,     itrn_pkg::CH_C, 12'd100};
      5'd7:    word = '{itrn_pkg::OP_PAIR_HI, itrn_pkg::CH_X, 12'd90};
      5'd8:    word = '{itrn_pkg::OP_PAIR_LO, itrn_pkg::CH_C, 12'd90};
      5'd9:    word = '{itrn_pkg::OP_RPT,     itrn_pkg::CH_L, 12'd50};
      5'd10:   word = '{itrn_pkg::OP_PAIR_HI, itrn_pkg::CH_X, 12'd40};
      5'd11:   word = '{itrn_pkg::OP_PAIR_LO, itrn_pkg::CH_L, 12'd40};
      5'd12:   word = '{itrn_pkg::OP_RPT,     itrn_pkg::CH_X, 12'd10};
      5'd13:   word = '{itrn_pkg::OP_PAIR_HI, itrn_pkg::CH_I, 12'd9};
      5'd14:   word = '{itrn_pkg::OP_PAIR_LO, itrn_pkg::CH_X, 12'd9};
      5'd15:   word = '{itrn_pkg::OP_RPT,     itrn_pkg::CH_V, 12'd5};
      5'd16:   word = '{itrn_pkg::OP_PAIR_HI, itrn_pkg::CH_I, 12'd4};
      5'd17:   word = '{itrn_pkg::OP_PAIR_LO, itrn_pkg::CH_V, 12'd4};
      5'd18:   word = '{itrn_pkg::OP_RPT,     itrn_pkg::CH_I, 12'd1};
      default: word = '{itrn_pkg::OP_RPT,     itrn_pkg::CH_I, 12'd1};
    endcase
  end

endmodule

>>> src/itrn_dp.sv
module itrn_dp (
  input  logic                         clk,
  input  logic                         load,
  input  logic [itrn_pkg::REM_W-1:0]   load_value,
  input  logic [itrn_pkg::REM_W-1:0]   amount,
  input  itrn_pkg::seq_ctl_t           ctl,
  output itrn_pkg::dp_flags_t          flags
);

  logic [itrn_pkg::REM_W-1:0] rem_r;
  logic [itrn_pkg::REM_W-1:0] rem_nxt;

  always_comb begin
    rem_nxt = rem_r;
    if (load) begin
      rem_nxt = load_value;
    end else if (ctl.sub) begin
      rem_nxt = rem_r - amount;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  assign flags.ge    = (rem_r >= amount);
  assign flags.drain = (rem_r == amount);

endmodule

>>> src/itrn_seq.sv
module itrn_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         go,
  input  itrn_pkg::ucode_t             word,
  input  itrn_pkg::dp_flags_t          flags,
  output logic [itrn_pkg::STEP_W-1:0]  step,
  output logic                         busy,
  output itrn_pkg::seq_ctl_t           ctl
);

  logic [itrn_pkg::STEP_W-1:0] step_r;
  logic [itrn_pkg::STEP_W-1:0] step_nxt;
  logic                        busy_r;
  logic                        busy_nxt;

  always_comb begin
    ctl      = '0;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r && go) begin
      unique case (word.op)
        itrn_pkg::OP_RPT: begin
          if (flags.ge) begin
            ctl.emit = 1'b1;
            ctl.sub  = 1'b1;
            ctl.last = flags.drain;
            if (flags.drain) begin
              busy_nxt = 1'b0;
            end
          end else begin
            step_nxt = step_r + itrn_pkg::STEP_W'(1);
          end
        end
        itrn_pkg::OP_PAIR_HI: begin
          if (flags.ge) begin
            ctl.emit = 1'b1;
            step_nxt = step_r + itrn_pkg::STEP_W'(1);
          end else begin
            step_nxt = step_r + itrn_pkg::STEP_W'(2);
          end
        end
        itrn_pkg::OP_PAIR_LO: begin
          ctl.emit = 1'b1;
          ctl.sub  = 1'b1;
          ctl.last = flags.drain;
          step_nxt = step_r + itrn_pkg::STEP_W'(1);
          if (flags.drain) begin
            busy_nxt = 1'b0;
          end
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign step = step_r;
  assign busy = busy_r;

  a_step_in_rom: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= itrn_pkg::STEP_LAST)
    else $error("sequencer ran past the end of the program");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && ctl.last) |=> !busy_r)
    else $error("sequencer still busy after the final character");

  a_sub_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.sub |-> flags.ge)
    else $error("subtraction would underflow the remainder");

endmodule

>>> src/integer_to_roman_numeral.sv
// Converts a 16-bit value to its subtractive Roman numeral, one character per output transaction.
// A zero or above-range value gives one status transaction, registered in the cycle after accept.
// A valid value runs through the 19-step control program, which emits a character or moves on
// to a later step whenever the output register can take a new transaction.
// A new value is taken once the previous numeral is finished and its last character can move.
// Reset (rst_n low, synchronous) empties the output register and parks the sequencer.
module integer_to_roman_numeral (
  input  logic        clk,
  input  logic        rst_n,
  itrn_in_if.sink     in_ch,
  itrn_out_if.source  out_ch
);

  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic [itrn_pkg::CHAR_W-1:0]    out_char_r;
  logic [itrn_pkg::CHAR_W-1:0]    out_char_nxt;
  logic                           out_last_r;
  logic                           out_last_nxt;
  itrn_pkg::status_t              out_status_r;
  itrn_pkg::status_t              out_status_nxt;

  logic                           go;
  logic                           accept;
  logic                           is_zero;
  logic                           is_range;
  logic                           start;
  logic                           busy;
  logic [itrn_pkg::STEP_W-1:0]    step;
  itrn_pkg::ucode_t               word;
  itrn_pkg::dp_flags_t            flags;
  itrn_pkg::seq_ctl_t             ctl;

  assign go           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !busy && go;
  assign accept       = in_ch.valid && in_ch.ready;
  assign is_zero      = (in_ch.value == '0);
  assign is_range     = (in_ch.value > itrn_pkg::MAX_VALUE);
  assign start        = accept && !is_zero && !is_range;

  itrn_rom u_rom (
    .step (step),
    .word (word)
  );

  itrn_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .go    (go),
    .word  (word),
    .flags (flags),
    .step  (step),
    .busy  (busy),
    .ctl   (ctl)
  );

  itrn_dp u_dp (
    .clk        (clk),
    .load       (start),
    .load_value (in_ch.value[itrn_pkg::REM_W-1:0]),
    .amount     (word.amount),
    .ctl        (ctl),
    .flags      (flags)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    if (accept && (is_zero || is_range)) begin
      out_valid_nxt  = 1'b1;
      out_char_nxt   = itrn_pkg::CH_NONE;
      out_last_nxt   = 1'b1;
      out_status_nxt = is_zero ? itrn_pkg::ST_ZERO : itrn_pkg::ST_RANGE;
    end else if (ctl.emit) begin
      out_valid_nxt  = 1'b1;
      out_char_nxt   = word.chr;
      out_last_nxt   = ctl.last;
      out_status_nxt = itrn_pkg::ST_OK;
    end else if (out_ch.ready) begin
      out_valid_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.status    = out_status_r;

  a_ok_has_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == itrn_pkg::ST_OK) |-> out_char_r != itrn_pkg::CH_NONE)
    else $error("numeral transaction carries no character");

  a_status_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != itrn_pkg::ST_OK)
      |-> (out_last_r && out_char_r == itrn_pkg::CH_NONE))
    else $error("status transaction is not a lone final transaction");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy)
    else $error("sequencer did not start on an accepted value");

endmodule

>>> tb/sv/numeral_checker.sv
module numeral_checker (
  input  logic clk,
  input  logic rst_n,
  itrn_in_if   in_mon,
  itrn_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   chars_seen,
  output int   flags_seen
);

  typedef struct packed {
    logic [itrn_pkg::VALUE_W-1:0] src;
    logic [itrn_pkg::CHAR_W-1:0]  char_code;
    logic                         last;
    itrn_pkg::status_t            status;
  } roman_char_t;

  localparam logic [itrn_pkg::CHAR_W-1:0] UNIT_SYM[4] =
    '{itrn_pkg::CH_M, itrn_pkg::CH_C, itrn_pkg::CH_X, itrn_pkg::CH_I};
  localparam logic [itrn_pkg::CHAR_W-1:0] FIVE_SYM[4] =
    '{itrn_pkg::CH_NONE, itrn_pkg::CH_D, itrn_pkg::CH_L, itrn_pkg::CH_V};
  localparam logic [itrn_pkg::CHAR_W-1:0] TEN_SYM[4] =
    '{itrn_pkg::CH_NONE, itrn_pkg::CH_M, itrn_pkg::CH_C, itrn_pkg::CH_X};

  roman_char_t expected_chars[$];
  roman_char_t want;

  function automatic void predict_numeral(input logic [itrn_pkg::VALUE_W-1:0] v);
    logic [itrn_pkg::CHAR_W-1:0] sym[$];
    roman_char_t                 entry;
    int                          digit;
    int                          weight;
    if (v == '0) begin
      entry = '{v, itrn_pkg::CH_NONE, 1'b1, itrn_pkg::ST_ZERO};
      expected_chars.push_back(entry);
    end else if (v > itrn_pkg::MAX_VALUE) begin
      entry = '{v, itrn_pkg::CH_NONE, 1'b1, itrn_pkg::ST_RANGE};
      expected_chars.push_back(entry);
    end else begin
      weight = 1000;
      for (int place = 0; place < 4; place++) begin
        digit = (int'(v) / weight) % 10;
        if (digit == 9) begin
          sym.push_back(UNIT_SYM[place]);
          sym.push_back(TEN_SYM[place]);
        end else if (digit == 4) begin
          sym.push_back(UNIT_SYM[place]);
          sym.push_back(FIVE_SYM[place]);
        end else begin
          if (digit >= 5) begin
            sym.push_back(FIVE_SYM[place]);
          end
          for (int k = 0; k < digit % 5; k++) begin
            sym.push_back(UNIT_SYM[place]);
          end
        end
        weight = weight / 10;
      end
      for (int k = 0; k < sym.size(); k++) begin
        entry = '{v, sym[k], (k == sym.size() - 1), itrn_pkg::ST_OK};
        expected_chars.push_back(entry);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        predict_numeral(in_mon.value);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (out_mon.status == itrn_pkg::ST_OK) begin
          chars_seen <= chars_seen + 1;
        end else begin
          flags_seen <= flags_seen + 1;
        end
        if (expected_chars.size() == 0) begin
          if (fail_count < 10) begin
            $display("ERROR: unexpected transaction char=%02h last=%0b status=%0d",
                     out_mon.char_code, out_mon.last, out_mon.status);
          end
          fail_count <= fail_count + 1;
        end else begin
          want = expected_chars.pop_front();
          if (out_mon.char_code !== want.char_code || out_mon.last !== want.last ||
              out_mon.status !== want.status) begin
            if (fail_count < 10) begin
              $display("ERROR: value %0d expected char=%02h last=%0b status=%0d,",
                       want.src, want.char_code, want.last, want.status);
              $display("       got char=%02h last=%0b status=%0d",
                       out_mon.char_code, out_mon.last, out_mon.status);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_chars.size();
    end
  end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 355;
  localparam logic [itrn_pkg::VALUE_W-1:0] DIRECTED[25] = '{
    16'd1, 16'd3999, 16'd4000, 16'd0, 16'd65535, 16'd3888, 16'd4, 16'd9, 16'd40,
    16'd90, 16'd400, 16'd900, 16'd5, 16'd10, 16'd50, 16'd100, 16'd500, 16'd1000,
    16'd1994, 16'd2421, 16'd3, 16'd8, 16'd3449, 16'd1666, 16'd32768
  };

  logic clk = 1'b0;
  logic rst_n;
  logic idle_on;
  int   hold_seq;
  int   sent_count;
  int   fail_count;
  int   pending;
  int   chars_seen;
  int   flags_seen;

  itrn_in_if  in_ch ();
  itrn_out_if out_ch ();

  integer_to_roman_numeral u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  numeral_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .chars_seen (chars_seen),
    .flags_seen (flags_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_value(input logic [itrn_pkg::VALUE_W-1:0] v);
    while (idle_on && $urandom_range(0, 99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    sent_count++;
  endtask

  // The receiver takes hold-off requests and counts them out itself.
  initial begin
    int hold_left;
    int hold_done;
    hold_left = 0;
    hold_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_done) begin
        hold_done = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
    $display("integer_to_roman_numeral test failed");
    $finish;
  end

  initial begin
    logic [itrn_pkg::VALUE_W-1:0] v;
    int                           r;
    rst_n = 1'b0;
    idle_on = 1'b1;
    hold_seq = 0;
    sent_count = 0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      send_value(DIRECTED[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = !(n >= 150 && n < 230);
      if (n == 60 || n == 300) begin
        hold_seq++;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
        v = '0;
      end else if (r < 17) begin
        v = itrn_pkg::VALUE_W'($urandom_range(4000, 65535));
      end else if (r < 25) begin
        v = itrn_pkg::VALUE_W'($urandom_range(3980, 4020));
      end else begin
        v = itrn_pkg::VALUE_W'($urandom_range(1, 3999));
      end
      send_value(v);
    end
    in_ch.valid <= 1'b0;
    idle_on = 1'b1;

    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (50) @(posedge clk);

    $display("Sent %0d values; checked %0d numeral characters and %0d status transactions.",
             sent_count, chars_seen, flags_seen);
    $display("The run included two %0d-cycle output hold-offs and an idle-free stretch.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("integer_to_roman_numeral test passed");
    end else begin
      $display("integer_to_roman_numeral test failed");
    end
    $finish;
  end

endmodule
